// ----- rtl/core/ale_pkg.sv -----
package ale_pkg;

    // List geometry
    localparam int MAX_ELEMS  = 64;
    localparam int ELEM_WIDTH = 32;

    // Fixed field widths of the command and response transactions
    localparam int KIND_W  = 4;
    localparam int POS_W   = 6;
    localparam int WORD_W  = 32;
    localparam int COUNT_W = 7;

    // Derived widths
    localparam int IDX_W = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
    localparam int CNT_W = $clog2(MAX_ELEMS + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Command codes
    localparam logic [KIND_W-1:0] CMD_CLEAR     = KIND_W'(0);
    localparam logic [KIND_W-1:0] CMD_INS_FIRST = KIND_W'(1);
    localparam logic [KIND_W-1:0] CMD_INS_AT    = KIND_W'(2);
    localparam logic [KIND_W-1:0] CMD_INS_LAST  = KIND_W'(3);
    localparam logic [KIND_W-1:0] CMD_DEL_FIRST = KIND_W'(4);
    localparam logic [KIND_W-1:0] CMD_DEL_AT    = KIND_W'(5);
    localparam logic [KIND_W-1:0] CMD_DEL_LAST  = KIND_W'(6);
    localparam logic [KIND_W-1:0] CMD_GET       = KIND_W'(7);
    localparam logic [KIND_W-1:0] CMD_SET       = KIND_W'(8);
    localparam logic [KIND_W-1:0] CMD_SEARCH    = KIND_W'(9);

    typedef logic [ELEM_WIDTH-1:0] t_elem;

    // Narrow a signed input word to the stored element width
    function automatic t_elem value_in(input logic signed [WORD_W-1:0] v);
        logic signed [63:0] w;
        w = 64'(v);
        return w[ELEM_WIDTH-1:0];
    endfunction

    // Sign extend a stored element and present it as a signed output word
    function automatic logic signed [WORD_W-1:0] value_out(input t_elem e);
        logic signed [63:0] w;
        w = 64'(signed'(e));
        return w[WORD_W-1:0];
    endfunction

endpackage

// ----- rtl/core/ale_cmd_if.sv -----
interface ale_cmd_if import ale_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic [POS_W-1:0]         position;
    logic signed [WORD_W-1:0] item_value;

    modport source (output valid, output kind, output position, output item_value,
                    input ready);
    modport sink   (input valid, input kind, input position, input item_value,
                    output ready);
endinterface

// ----- rtl/core/ale_rsp_if.sv -----
interface ale_rsp_if import ale_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] read_value;
    logic                     found;
    logic                     applied;
    logic [COUNT_W-1:0]       entry_count;
    logic                     is_empty;
    logic                     index_effective;

    modport source (output valid, output read_value, output found, output applied,
                    output entry_count, output is_empty, output index_effective,
                    input ready);
    modport sink   (input valid, input read_value, input found, input applied,
                    input entry_count, input is_empty, input index_effective,
                    output ready);
endinterface

// ----- rtl/core/array_list_engine_top.sv -----
// Contiguous array list engine. Entries live in one single-port-write, registered-read
// memory of MAX_ELEMS words with a kept entry count; one command transaction yields one
// response transaction. Clear, insert last, delete last, set and unused codes go from
// idle straight to the done state, and get passes through S_GET on its way there; the
// response turns valid in the same cycle as the engine is ready again. Insert
// first/at shifts the (count - index) later entries up and delete first/at shifts the
// (count - 1 - index) later entries down, one memory read and one write back per cycle;
// search reads every effective entry. The finished result waits in S_DONE until the
// output register is free or being emptied.
// A new command is taken whenever the sequencer is idle, even while the previous
// response still waits in the output register. Memory words that were never written
// may be read while idle but never feed a response.
module array_list_engine_top import ale_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ale_cmd_if.sink     i_cmd,
    ale_rsp_if.source   o_rsp
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SHUP = 3'd1;  // shift entries up, then write the new one
    localparam logic [2:0] S_SHDN = 3'd2;  // shift entries down over the deleted one
    localparam logic [2:0] S_SRCH = 3'd3;  // walk effective entries against the key
    localparam logic [2:0] S_GET  = 3'd4;  // pick up the read word
    localparam logic [2:0] S_DONE = 3'd5;  // hand the result to the output register

    logic [2:0]        r_state;
    logic [CNT_W-1:0]  r_count;

    // Sequencer working registers
    logic [IDX_W-1:0]  r_addr;   // next read address
    logic [IDX_W-1:0]  r_wa;     // write-back address of the read in flight
    logic [CNT_W-1:0]  r_left;   // reads still to issue
    logic              r_pend;   // a read is in flight, its data lands in r_rd_data
    logic [IDX_W-1:0]  r_pos;
    t_elem             r_val;

    // Result under construction
    logic                     r_found;
    logic                     r_applied;
    logic                     r_eff;
    logic signed [WORD_W-1:0] r_rdv;

    // Output register
    logic                     r_ov;
    logic signed [WORD_W-1:0] r_o_rdv;
    logic                     r_o_found;
    logic                     r_o_applied;
    logic [COUNT_W-1:0]       r_o_count;
    logic                     r_o_empty;
    logic                     r_o_eff;

    // Entry memory
    t_elem             mem [MAX_ELEMS];
    t_elem             r_rd_data;
    logic              w_en;
    logic [IDX_W-1:0]  w_addr;
    t_elem             w_data;
    logic [IDX_W-1:0]  rd_addr;

    // Decode of the command on offer
    logic              accept;
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  pos_idx;
    logic [CNT_W-1:0]  pos_cnt;
    logic              eff;
    logic              room;
    logic              nonempty;
    t_elem             val_in;
    logic              issue;

    assign kind     = i_cmd.kind;
    assign pos_idx  = IDX_W'(i_cmd.position);
    assign pos_cnt  = CNT_W'(i_cmd.position);
    assign eff      = CMP_W'(i_cmd.position) < CMP_W'(r_count);
    assign room     = r_count < CNT_W'(MAX_ELEMS);
    assign nonempty = r_count != '0;
    assign val_in   = value_in(i_cmd.item_value);

    assign i_cmd.ready = (r_state == S_IDLE);
    assign accept      = i_cmd.valid && i_cmd.ready;

    // Issue a read in any walking state while reads remain
    assign issue   = (r_state == S_SHUP || r_state == S_SHDN || r_state == S_SRCH)
                     && r_left != '0;
    assign rd_addr = (r_state == S_IDLE) ? pos_idx : r_addr;

    // Write port: direct writes on acceptance, write-backs and the inserted entry while shifting
    always_comb begin
        w_en   = 1'b0;
        w_addr = r_wa;
        w_data = r_rd_data;
        case (r_state)
            S_IDLE: begin
                if (accept && kind == CMD_INS_LAST && room) begin
                    w_en   = 1'b1;
                    w_addr = IDX_W'(r_count);
                    w_data = val_in;
                end else if (accept && kind == CMD_SET && eff) begin
                    w_en   = 1'b1;
                    w_addr = pos_idx;
                    w_data = val_in;
                end
            end
            S_SHUP: begin
                if (r_pend) begin
                    w_en = 1'b1;
                end else if (r_left == '0) begin
                    // Gap is open: drop the new entry in
                    w_en   = 1'b1;
                    w_addr = r_pos;
                    w_data = r_val;
                end
            end
            S_SHDN: begin
                w_en = r_pend;
            end
            default: begin
                w_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            mem[w_addr] <= w_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_left  <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (o_rsp.valid && o_rsp.ready) begin
                r_ov <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_pos     <= pos_idx;
                        r_val     <= val_in;
                        r_eff     <= eff;
                        r_found   <= 1'b0;
                        r_applied <= 1'b0;
                        r_rdv     <= '0;
                        r_pend    <= 1'b0;
                        r_state   <= S_DONE;
                        case (kind)
                            CMD_CLEAR: begin
                                r_count   <= '0;
                                r_applied <= 1'b1;
                            end
                            CMD_INS_FIRST: begin
                                if (room) begin
                                    r_pos     <= '0;
                                    r_addr    <= IDX_W'(r_count - 1'b1);
                                    r_left    <= r_count;
                                    r_count   <= r_count + 1'b1;
                                    r_applied <= 1'b1;
                                    r_state   <= S_SHUP;
                                end
                            end
                            CMD_INS_AT: begin
                                if (room && eff) begin
                                    r_addr    <= IDX_W'(r_count - 1'b1);
                                    r_left    <= r_count - pos_cnt;
                                    r_count   <= r_count + 1'b1;
                                    r_applied <= 1'b1;
                                    r_state   <= S_SHUP;
                                end
                            end
                            CMD_INS_LAST: begin
                                if (room) begin
                                    r_count   <= r_count + 1'b1;
                                    r_applied <= 1'b1;
                                end
                            end
                            CMD_DEL_FIRST: begin
                                if (nonempty) begin
                                    r_addr    <= IDX_W'(1);
                                    r_left    <= r_count - 1'b1;
                                    r_count   <= r_count - 1'b1;
                                    r_applied <= 1'b1;
                                    r_state   <= S_SHDN;
                                end
                            end
                            CMD_DEL_AT: begin
                                if (eff) begin
                                    r_addr    <= pos_idx + 1'b1;
                                    r_left    <= r_count - 1'b1 - pos_cnt;
                                    r_count   <= r_count - 1'b1;
                                    r_applied <= 1'b1;
                                    r_state   <= S_SHDN;
                                end
                            end
                            CMD_DEL_LAST: begin
                                if (nonempty) begin
                                    r_count   <= r_count - 1'b1;
                                    r_applied <= 1'b1;
                                end
                            end
                            CMD_GET: begin
                                // Read at the position is already under way
                                if (eff) begin
                                    r_applied <= 1'b1;
                                    r_state   <= S_GET;
                                end
                            end
                            CMD_SET: begin
                                r_applied <= eff;
                            end
                            CMD_SEARCH: begin
                                r_addr    <= '0;
                                r_left    <= r_count;
                                r_applied <= 1'b1;
                                r_state   <= S_SRCH;
                            end
                            default: begin
                                r_applied <= 1'b0;
                            end
                        endcase
                    end
                end

                S_SHUP: begin
                    // Walk downwards; each word lands one place higher in the cycle after its read
                    r_pend <= issue;
                    if (issue) begin
                        r_wa   <= r_addr + 1'b1;
                        r_addr <= r_addr - 1'b1;
                        r_left <= r_left - 1'b1;
                    end
                    if (!r_pend && r_left == '0) begin
                        r_state <= S_DONE;
                    end
                end

                S_SHDN: begin
                    // Walk upwards; each word lands one place lower in the cycle after its read
                    r_pend <= issue;
                    if (issue) begin
                        r_wa   <= r_addr - 1'b1;
                        r_addr <= r_addr + 1'b1;
                        r_left <= r_left - 1'b1;
                    end
                    if (!r_pend && r_left == '0) begin
                        r_state <= S_DONE;
                    end
                end

                S_SRCH: begin
                    r_pend <= issue;
                    if (issue) begin
                        r_addr <= r_addr + 1'b1;
                        r_left <= r_left - 1'b1;
                    end
                    if (r_pend && r_rd_data == r_val) begin
                        r_found <= 1'b1;
                    end
                    if (!r_pend && r_left == '0) begin
                        r_state <= S_DONE;
                    end
                end

                S_GET: begin
                    r_rdv   <= value_out(r_rd_data);
                    r_state <= S_DONE;
                end

                S_DONE: begin
                    // Hold until the output register is free or being emptied
                    if (!r_ov || o_rsp.ready) begin
                        r_ov    <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Output payload, loaded as the result leaves the sequencer
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_ov || o_rsp.ready)) begin
            r_o_rdv     <= r_rdv;
            r_o_found   <= r_found;
            r_o_applied <= r_applied;
            r_o_count   <= COUNT_W'(r_count);
            r_o_empty   <= (r_count == '0);
            r_o_eff     <= r_eff;
        end
    end

    assign o_rsp.valid           = r_ov;
    assign o_rsp.read_value      = r_o_rdv;
    assign o_rsp.found           = r_o_found;
    assign o_rsp.applied         = r_o_applied;
    assign o_rsp.entry_count     = r_o_count;
    assign o_rsp.is_empty        = r_o_empty;
    assign o_rsp.index_effective = r_o_eff;

endmodule
